// ===== design/wgm_pkg.sv =====
`timescale 1ns / 1ps

package wgm_pkg;

    localparam int MAX_PATTERN  = 32;
    localparam int VEC_W        = MAX_PATTERN + 1;
    localparam int LEN_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int NUM_PAT_REGS = 4;
    localparam int PAT_REG_W    = 64;
    localparam int BYTES_PER_REG = PAT_REG_W / BYTE_W;
    localparam int PAT_IDX_W    = $clog2(NUM_PAT_REGS);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [BYTE_W-1:0] STAR_CHAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] QMARK_CHAR = 8'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_A = 3'd0,
        CFG_PAT_B = 3'd1,
        CFG_PAT_C = 3'd2,
        CFG_PAT_D = 3'd3,
        CFG_LEN   = 3'd4
    } t_cfg_idx;

    // signals handed from one position cell to the next
    typedef struct packed {
        logic cur_carry;   // closed current bit, in front of a star
        logic advance;     // position moves forward on this byte
        logic next_carry;  // closed next bit, in front of a star
    } t_link;

    typedef struct packed {
        logic full_match;
        logic text_done;
    } t_result;

endpackage

// ===== design/wgm_if.sv =====
`timescale 1ns / 1ps

interface wgm_text_if;
    logic                       valid;
    logic                       ready;
    logic [wgm_pkg::BYTE_W-1:0] text_byte;
    logic                       no_byte;
    logic                       is_last;

    modport source (output valid, text_byte, no_byte, is_last, input ready);
    modport sink   (input valid, text_byte, no_byte, is_last, output ready);
endinterface

interface wgm_result_if;
    logic valid;
    logic ready;
    logic full_match;
    logic text_done;

    modport source (output valid, full_match, text_done, input ready);
    modport sink   (input valid, full_match, text_done, output ready);
endinterface

// ===== design/wgm_cell.sv =====
`timescale 1ns / 1ps

module wgm_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_last,
    input  logic                       i_no_byte,
    input  logic                       i_start,
    input  logic                       i_enable,
    input  logic [wgm_pkg::BYTE_W-1:0] i_text_byte,
    input  logic [wgm_pkg::BYTE_W-1:0] i_pattern_byte,
    input  wgm_pkg::t_link             i_link,
    output wgm_pkg::t_link             o_link,
    output logic                       o_next_bit
);

    logic r_active;
    logic n_active;
    logic w_star;
    logic w_hit;
    logic w_cur;
    logic w_raw;
    logic w_next;

    assign w_star = i_enable && (i_pattern_byte == wgm_pkg::STAR_CHAR);
    assign w_hit  = i_enable && !w_star &&
                    ((i_pattern_byte == wgm_pkg::QMARK_CHAR) || (i_pattern_byte == i_text_byte));

    assign w_cur  = r_active | i_link.cur_carry;
    assign w_raw  = i_no_byte ? w_cur : ((w_cur & w_star) | i_link.advance);
    assign w_next = w_raw | i_link.next_carry;

    assign o_link.cur_carry  = w_cur & w_star;
    assign o_link.advance    = w_cur & w_hit;
    assign o_link.next_carry = w_next & w_star;
    assign o_next_bit        = w_next;

    assign n_active = i_last ? i_start : w_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= i_start;
        end else if (i_accept) begin
            r_active <= n_active;
        end
    end

endmodule

// ===== design/wildcard_glob_matcher.sv =====
`timescale 1ns / 1ps

// Glob matcher: '*' matches any run (possibly empty), '?' one byte, others literal.
// Text channel (i_text): one byte per transfer; no_byte marks a transfer without a
// character, is_last ends the text and returns the matcher to the start position.
// Result channel (o_result): exactly one result per text transfer, in order.
// full_match tells whether the text so far matches the whole pattern; text_done
// echoes is_last.
// The result is registered (in the skid entry if the output register is held).
// Throughput: one text byte per cycle while the skid entry is empty. A row of 32
// position cells, one bit each, updates all pattern positions; star closure
// ripples through the row. A two-entry output stage (register plus skid) keeps
// i_text ready while one result waits; i_text drops ready only when both
// entries are full. Config: i_cfg_we writes register i_cfg_index (0..3 pattern
// bytes, 4 length); write only between texts or while no result is outstanding.
// Reset (synchronous, active low): pattern and length clear to zero, the
// position vector returns to the start position, output stage empties.

module wildcard_glob_matcher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wgm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wgm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wgm_text_if.sink                       i_text,
    wgm_result_if.source                   o_result
);

    localparam int N = wgm_pkg::MAX_PATTERN;

    logic [wgm_pkg::NUM_PAT_REGS-1:0][wgm_pkg::PAT_REG_W-1:0] r_pat;
    logic [wgm_pkg::LEN_W-1:0] r_len;
    logic [wgm_pkg::LEN_W-1:0] w_len_used;

    wgm_pkg::t_link         w_link [N+1];
    logic [wgm_pkg::VEC_W-1:0] w_next_vec;

    logic r_last_active;
    logic n_last_active;
    logic w_cur_last;
    logic w_raw_last;

    logic             w_accept;
    wgm_pkg::t_result w_new;
    wgm_pkg::t_result r_out;
    wgm_pkg::t_result r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
            r_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wgm_pkg::CFG_PAT_A, wgm_pkg::CFG_PAT_B,
                wgm_pkg::CFG_PAT_C, wgm_pkg::CFG_PAT_D: begin
                    r_pat[i_cfg_index[wgm_pkg::PAT_IDX_W-1:0]] <= i_cfg_data;
                end
                wgm_pkg::CFG_LEN: begin
                    r_len <= i_cfg_data[wgm_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_len_used = (r_len > wgm_pkg::LEN_W'(N)) ? wgm_pkg::LEN_W'(N) : r_len;

    assign w_accept = i_text.valid && i_text.ready;

    // position cells
    assign w_link[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        wgm_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_accept       (w_accept),
            .i_last         (i_text.is_last),
            .i_no_byte      (i_text.no_byte),
            .i_start        ((i == 0) ? 1'b1 : 1'b0),
            .i_enable       (wgm_pkg::LEN_W'(i) < w_len_used),
            .i_text_byte    (i_text.text_byte),
            .i_pattern_byte (r_pat[i / wgm_pkg::BYTES_PER_REG]
                                  [(i % wgm_pkg::BYTES_PER_REG) * wgm_pkg::BYTE_W +:
                                   wgm_pkg::BYTE_W]),
            .i_link         (w_link[i]),
            .o_link         (w_link[i+1]),
            .o_next_bit     (w_next_vec[i])
        );
    end

    // end position: never enabled, only receives from the last cell
    assign w_cur_last    = r_last_active | w_link[N].cur_carry;
    assign w_raw_last    = i_text.no_byte ? w_cur_last : w_link[N].advance;
    assign w_next_vec[N] = w_raw_last | w_link[N].next_carry;
    assign n_last_active = i_text.is_last ? 1'b0 : w_next_vec[N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_active <= 1'b0;
        end else if (w_accept) begin
            r_last_active <= n_last_active;
        end
    end

    assign w_new.full_match = w_next_vec[w_len_used];
    assign w_new.text_done  = i_text.is_last;

    // output register with skid entry
    assign i_text.ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_result.ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || o_result.ready) begin
            r_out_valid <= w_accept;
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (o_result.ready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || o_result.ready) begin
            r_out <= w_new;
        end else if (w_accept) begin
            r_skid <= w_new;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.full_match = r_out.full_match;
    assign o_result.text_done  = r_out.text_done;

endmodule
